@@ rtl/mcrpm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcrpm_pkg
// Shared types and codes for the ring pointer manager.
// ----------------------------------------------------------------------------
package mcrpm_pkg;

   localparam int MAX_PRODUCERS_DEF = 8;
   localparam int MAX_CONSUMERS_DEF = 8;
   localparam int POS_BITS_DEF      = 48;

   localparam int ACT_W    = 4;
   localparam int CLIENT_W = 3;
   localparam int AMT_W    = 47;
   localparam int OPOS_W   = 48;
   localparam int CSR_IDX_W = 1;

   localparam logic [ACT_W-1:0] ACT_REG_PROD   = 4'd0;
   localparam logic [ACT_W-1:0] ACT_REG_CONS   = 4'd1;
   localparam logic [ACT_W-1:0] ACT_RESERVE    = 4'd2;
   localparam logic [ACT_W-1:0] ACT_Q_WRITE    = 4'd3;
   localparam logic [ACT_W-1:0] ACT_FIN_WRITE  = 4'd4;
   localparam logic [ACT_W-1:0] ACT_CLAIM      = 4'd5;
   localparam logic [ACT_W-1:0] ACT_CLAIM_ALL  = 4'd6;
   localparam logic [ACT_W-1:0] ACT_Q_READ     = 4'd7;
   localparam logic [ACT_W-1:0] ACT_FIN_READ   = 4'd8;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_WAIT = 2'd1;
   localparam logic [1:0] ST_DOWN = 2'd2;
   localparam logic [1:0] ST_ERR  = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_RING_SIZE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SHUT_DOWN = 1'd1;

   typedef struct packed {
      logic [ACT_W-1:0]    action;
      logic [CLIENT_W-1:0] client;
      logic [AMT_W-1:0]    amount;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [OPOS_W-1:0] position;
      logic [AMT_W-1:0]  avail;
   } rsp_type;

   // scan control between sequencer and min unit
   typedef struct packed {
      logic start;
      logic prod_side;
   } scan_ctl_type;

endpackage

@@ rtl/mcrpm_min_scan.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcrpm_min_scan
// Shared distance/compare unit: walks one slot per cycle and keeps the
// minimum distance from the read back pointer.
// ----------------------------------------------------------------------------
module mcrpm_min_scan #(
   parameter int SLOTS    = mcrpm_pkg::MAX_PRODUCERS_DEF,
   parameter int POS_BITS = mcrpm_pkg::POS_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  mcrpm_pkg::scan_ctl_type   ctl,
   input  logic [POS_BITS-1:0]       seed,
   input  logic [POS_BITS-1:0]       base,
   input  logic                      slot_valid,
   input  logic [POS_BITS-1:0]       slot_pos,
   output logic [$clog2(SLOTS+1)-1:0] slot_idx,
   output logic                      done,
   output logic [POS_BITS-1:0]       best
);
   localparam int IW = $clog2(SLOTS+1);

   logic [IW-1:0]       idx_ff, idx_in;
   logic                busy_ff, busy_in;
   logic                any_ff, any_in;
   logic [POS_BITS-1:0] best_ff, best_in;
   logic [POS_BITS-1:0] d;

   assign d = slot_pos - base;

   // slot data arrives in the cycle after its index
   always_comb begin
      idx_in  = idx_ff;
      busy_in = busy_ff;
      any_in  = any_ff;
      best_in = best_ff;
      if (ctl.start) begin
         idx_in  = '0;
         busy_in = 1'b1;
         any_in  = 1'b0;
         best_in = seed - base;
         if (!ctl.prod_side) best_in = '0;
      end else if (busy_ff) begin
         if (idx_ff != '0) begin
            if (slot_valid && (!any_ff || d < best_ff)) best_in = d;
            if (slot_valid) any_in = 1'b1;
         end
         if (idx_ff == IW'(SLOTS)) busy_in = 1'b0;
         else idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
      any_ff  <= any_in;
      best_ff <= best_in;
   end

   assign slot_idx = idx_ff;
   assign done     = !busy_ff;
   assign best     = best_ff;
endmodule

@@ rtl/multi_client_ring_pointer_manager_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_client_ring_pointer_manager_top
// Ring position manager for several producers and consumers.
// Sequence: operands are read in S_RD, the request executes in S_EXEC and
//   the response is held in S_RSP; a finish write that leaves the write front
//   alone also passes S_FIN, and a finish that moves the oldest pointer walks
//   NS slots in S_SCAN/S_WAIT before S_FIN (NS the larger of MAX_PRODUCERS,
//   MAX_CONSUMERS; one slot a cycle through the shared min unit).
// Requests: one at a time; the next is accepted the cycle after the response leaves.
// Reset: synchronous, clears slot valid bits, write front and read back.
// ----------------------------------------------------------------------------
module multi_client_ring_pointer_manager_top #(
   parameter int MAX_PRODUCERS = mcrpm_pkg::MAX_PRODUCERS_DEF,
   parameter int MAX_CONSUMERS = mcrpm_pkg::MAX_CONSUMERS_DEF,
   parameter int POS_BITS      = mcrpm_pkg::POS_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  mcrpm_pkg::req_type                  req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output mcrpm_pkg::rsp_type                  rsp_data,
   input  logic                                csr_write,
   input  logic [mcrpm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mcrpm_pkg::AMT_W-1:0]         csr_data
);
   localparam int PB = POS_BITS;
   localparam int AW = mcrpm_pkg::AMT_W;
   localparam int OPOS = mcrpm_pkg::OPOS_W;
   localparam int NS = (MAX_PRODUCERS > MAX_CONSUMERS) ? MAX_PRODUCERS : MAX_CONSUMERS;
   localparam int SW = $clog2(NS + 1);
   localparam int PIW = (MAX_PRODUCERS > 1) ? $clog2(MAX_PRODUCERS) : 1;
   localparam int CIW = (MAX_CONSUMERS > 1) ? $clog2(MAX_CONSUMERS) : 1;
   localparam logic [PB-1:0] AMAX = PB'({AW{1'b1}});

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;
   localparam logic [2:0] S_EXEC = 3'd2;
   localparam logic [2:0] S_SCAN = 3'd3;
   localparam logic [2:0] S_WAIT = 3'd4;
   localparam logic [2:0] S_FIN  = 3'd5;
   localparam logic [2:0] S_RSP  = 3'd6;

   logic [2:0] state_ff, state_in;
   mcrpm_pkg::req_type req_ff;
   mcrpm_pkg::rsp_type rsp_ff, rsp_in;

   logic [AW-1:0] ring_size_ff;
   logic          shut_down_ff;

   logic [MAX_PRODUCERS-1:0] pv_ff;
   logic [MAX_CONSUMERS-1:0] cv_ff;
   logic [PB-1:0] pcom [MAX_PRODUCERS];
   logic [PB-1:0] pres [MAX_PRODUCERS];
   logic [PB-1:0] ccl  [MAX_CONSUMERS];
   logic [PB-1:0] crel [MAX_CONSUMERS];
   logic [PB-1:0] wf_ff, rb_ff;

   // registered per-request operand reads
   logic [PB-1:0] pcom_r, pres_r, ccl_r, crel_r;
   logic [PB-1:0] slot_r;
   logic          slotv_r;

   logic          prod_side_ff;
   logic          need_scan_ff;

   mcrpm_pkg::scan_ctl_type scan_ctl;
   logic [SW-1:0] scan_idx;
   logic          scan_done;
   logic [PB-1:0] scan_best;

   logic [mcrpm_pkg::CLIENT_W-1:0] c;
   logic [PIW-1:0] pi;
   logic [CIW-1:0] ci;
   logic p_ok, c_ok;
   assign c  = req_ff.client;
   assign pi = PIW'(c);
   assign ci = CIW'(c);
   assign p_ok = (32'(c) < MAX_PRODUCERS) && pv_ff[pi];
   assign c_ok = (32'(c) < MAX_CONSUMERS) && cv_ff[ci];

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RSP);
   assign rsp_data  = rsp_ff;

   // config
   always_ff @(posedge clock) begin
      if (reset) begin
         ring_size_ff <= AW'(65536);
         shut_down_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            mcrpm_pkg::CSR_RING_SIZE: ring_size_ff <= csr_data;
            mcrpm_pkg::CSR_SHUT_DOWN: shut_down_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // operand read stage
   always_ff @(posedge clock) begin
      if (state_ff == S_RD) begin
         pcom_r <= pcom[pi];
         pres_r <= pres[pi];
         ccl_r  <= ccl[ci];
         crel_r <= crel[ci];
      end
      if (prod_side_ff) begin
         slotv_r <= (32'(scan_idx) < MAX_PRODUCERS) && pv_ff[PIW'(scan_idx)];
         slot_r  <= pcom[PIW'(scan_idx)];
      end else begin
         slotv_r <= (32'(scan_idx) < MAX_CONSUMERS) && cv_ff[CIW'(scan_idx)];
         slot_r  <= crel[CIW'(scan_idx)];
      end
   end

   mcrpm_min_scan #(.SLOTS(NS), .POS_BITS(PB)) u_scan (
      .clock(clock), .reset(reset), .ctl(scan_ctl),
      .seed(wf_ff), .base(rb_ff),
      .slot_valid(slotv_r), .slot_pos(slot_r),
      .slot_idx(scan_idx), .done(scan_done), .best(scan_best)
   );

   // exec combinational
   logic [PB-1:0] amt_p, base_d, used_d, have_d, rel_d, p_new;
   logic [PB:0]   sum_w;
   logic [1:0]    st;
   logic [PB-1:0] opos;
   logic [AW-1:0] oav;
   logic do_reg_p, do_reg_c, do_res, do_claim, do_fw, do_fr, need_scan;
   logic [PB-1:0] have_s;
   logic [PB-1:0] camt;

   assign amt_p  = PB'(req_ff.amount);
   assign base_d = pcom_r - rb_ff;
   assign used_d = pres_r - rb_ff;
   assign have_d = wf_ff - ccl_r;
   assign rel_d  = ccl_r - crel_r;
   assign have_s = (have_d > AMAX) ? AMAX : have_d;

   always_comb begin
      st = mcrpm_pkg::ST_ERR; opos = '0; oav = '0;
      do_reg_p = 1'b0; do_reg_c = 1'b0; do_res = 1'b0; do_claim = 1'b0;
      do_fw = 1'b0; do_fr = 1'b0; need_scan = 1'b0;
      p_new = '0; camt = amt_p; sum_w = '0;
      unique case (req_ff.action) inside
         mcrpm_pkg::ACT_REG_PROD: begin
            if (!((32'(c) < MAX_PRODUCERS) && pv_ff[pi]) && 32'(c) < MAX_PRODUCERS) begin
               st = mcrpm_pkg::ST_OK; opos = OPOS'(wf_ff); do_reg_p = 1'b1;
            end
         end
         mcrpm_pkg::ACT_REG_CONS: begin
            if (!((32'(c) < MAX_CONSUMERS) && cv_ff[ci]) && 32'(c) < MAX_CONSUMERS) begin
               st = mcrpm_pkg::ST_OK; opos = OPOS'(rb_ff); do_reg_c = 1'b1;
            end
         end
         mcrpm_pkg::ACT_FIN_WRITE: begin
            sum_w = {1'b0, base_d} + {1'b0, amt_p};
            if (p_ok && amt_p != '0 && base_d <= PB'(ring_size_ff)
                && sum_w <= (PB+1)'(ring_size_ff)) begin
               st = mcrpm_pkg::ST_OK; p_new = pcom_r + amt_p;
               opos = OPOS'(p_new); do_fw = 1'b1; need_scan = (pcom_r == wf_ff);
            end
         end
         mcrpm_pkg::ACT_RESERVE, mcrpm_pkg::ACT_Q_WRITE: begin
            sum_w = {1'b0, used_d} + {1'b0, amt_p};
            if (p_ok && !(req_ff.action == mcrpm_pkg::ACT_RESERVE && amt_p == '0)
                && used_d <= PB'(ring_size_ff)) begin
               if (shut_down_ff) st = mcrpm_pkg::ST_DOWN;
               else if (req_ff.action == mcrpm_pkg::ACT_Q_WRITE) begin
                  st = mcrpm_pkg::ST_OK; opos = OPOS'(pres_r);
                  oav = AW'(PB'(ring_size_ff) - used_d);
               end else if (sum_w > (PB+1)'(ring_size_ff)) st = mcrpm_pkg::ST_WAIT;
               else begin
                  st = mcrpm_pkg::ST_OK; opos = OPOS'(pres_r); oav = req_ff.amount;
                  p_new = pres_r + amt_p; do_res = 1'b1;
               end
            end
         end
         mcrpm_pkg::ACT_FIN_READ: begin
            if (c_ok && amt_p != '0 && !(rel_d < amt_p)) begin
               st = mcrpm_pkg::ST_OK; p_new = crel_r + amt_p;
               opos = OPOS'(p_new); do_fr = 1'b1; need_scan = (crel_r == rb_ff);
            end
         end
         mcrpm_pkg::ACT_CLAIM, mcrpm_pkg::ACT_CLAIM_ALL, mcrpm_pkg::ACT_Q_READ: begin
            if (c_ok && !(req_ff.action == mcrpm_pkg::ACT_CLAIM && amt_p == '0)) begin
               if (shut_down_ff) st = mcrpm_pkg::ST_DOWN;
               else if (req_ff.action == mcrpm_pkg::ACT_Q_READ) begin
                  if (have_s < amt_p) st = mcrpm_pkg::ST_WAIT;
                  else begin
                     st = mcrpm_pkg::ST_OK; opos = OPOS'(ccl_r); oav = AW'(have_s);
                  end
               end else begin
                  if (req_ff.action == mcrpm_pkg::ACT_CLAIM_ALL) camt = have_s;
                  if (camt == '0 || have_s < camt) st = mcrpm_pkg::ST_WAIT;
                  else begin
                     st = mcrpm_pkg::ST_OK; opos = OPOS'(ccl_r); oav = AW'(camt);
                     p_new = ccl_r + camt; do_claim = 1'b1;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      scan_ctl = '0;
      scan_ctl.prod_side = prod_side_ff;
      unique case (state_ff)
         S_IDLE: if (req_valid) state_in = S_RD;
         S_RD:   state_in = S_EXEC;
         S_EXEC: begin
            if (need_scan) begin
               scan_ctl.start = 1'b1;
               scan_ctl.prod_side = do_fw;
               state_in = S_SCAN;
            end else if (do_fw) state_in = S_FIN;
            else state_in = S_RSP;
         end
         S_SCAN: state_in = S_WAIT;
         S_WAIT: if (scan_done) state_in = S_FIN;
         S_FIN:  state_in = S_RSP;
         S_RSP:  if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_in = '{status: st, position: opos, avail: oav};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pv_ff <= '0;
         cv_ff <= '0;
         wf_ff <= '0;
         rb_ff <= '0;
         prod_side_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_EXEC) begin
            prod_side_ff <= do_fw;
            if (do_reg_p) pv_ff[pi] <= 1'b1;
            if (do_reg_c) cv_ff[ci] <= 1'b1;
         end
         if (state_ff == S_FIN) begin
            if (prod_side_ff) begin
               if (need_scan_ff) begin
                  wf_ff <= rb_ff + scan_best;
                  if (cv_ff == '0) rb_ff <= rb_ff + scan_best;
               end else if (cv_ff == '0) rb_ff <= wf_ff;
            end else begin
               rb_ff <= rb_ff + scan_best;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) req_ff <= req_data;
      if (state_ff == S_EXEC) begin
         rsp_ff <= rsp_in;
         need_scan_ff <= need_scan;
         if (do_reg_p) begin pcom[pi] <= wf_ff; pres[pi] <= wf_ff; end
         if (do_reg_c) begin ccl[ci] <= rb_ff; crel[ci] <= rb_ff; end
         if (do_res)   pres[pi] <= p_new;
         if (do_fw)    pcom[pi] <= p_new;
         if (do_claim) ccl[ci]  <= p_new;
         if (do_fr)    crel[ci] <= p_new;
      end
   end
endmodule

@@ rtl/mcrpm_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcrpm_checker
// Port-level checks for the ring pointer manager.
// ----------------------------------------------------------------------------
module mcrpm_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input mcrpm_pkg::rsp_type rsp_data
);
   a_no_ready_with_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("ready while response pending");
   a_rsp_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !rsp_valid) else $error("response too early");
   a_not_ok_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != mcrpm_pkg::ST_OK) |->
      (rsp_data.position == '0 && rsp_data.avail == '0)) else $error("nonzero fields");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("response dropped");
endmodule

bind multi_client_ring_pointer_manager_top mcrpm_checker u_mcrpm_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
);

@@ tb/multi_client_ring_pointer_manager_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_client_ring_pointer_manager_top_tb
// Self-checking bench for the ring pointer manager: directed table of
// requests, then random producer/consumer traffic, checked against a
// behavioral model of the slot pointers, write front and read back.
// ----------------------------------------------------------------------------
module multi_client_ring_pointer_manager_top_tb;

   localparam int NSLOT = 8;
   localparam logic [47:0] PMASK = 48'hFFFF_FFFF_FFFF;
   localparam logic [46:0] AMAX = {47{1'b1}};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   mcrpm_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   mcrpm_pkg::rsp_type rsp_data;
   logic csr_write = 1'b0;
   logic [mcrpm_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [mcrpm_pkg::AMT_W-1:0] csr_data = '0;

   multi_client_ring_pointer_manager_top DUT (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // model state
   logic [46:0] m_ring;
   logic m_down;
   logic p_ok [NSLOT];
   logic [47:0] p_com [NSLOT];
   logic [47:0] p_res [NSLOT];
   logic c_ok [NSLOT];
   logic [47:0] c_clm [NSLOT];
   logic [47:0] c_rel [NSLOT];
   logic [47:0] wfront, rback;

   mcrpm_pkg::rsp_type pending_rsp [$];
   int errors = 0;
   int send_idle = 0, recv_idle = 0;

   function automatic mcrpm_pkg::rsp_type mk(logic [1:0] st, logic [47:0] p, logic [46:0] a);
      mcrpm_pkg::rsp_type r;
      r.status = st;
      r.position = (st == mcrpm_pkg::ST_OK) ? p : '0;
      r.avail = (st == mcrpm_pkg::ST_OK) ? a : '0;
      return r;
   endfunction

   function automatic void model_reset();
      m_ring = 47'd65536;
      m_down = 1'b0;
      wfront = '0;
      rback = '0;
      for (int i = 0; i < NSLOT; i++) begin
         p_ok[i] = 1'b0; c_ok[i] = 1'b0;
         p_com[i] = '0; p_res[i] = '0; c_clm[i] = '0; c_rel[i] = '0;
      end
   endfunction

   function automatic logic any_cons();
      for (int i = 0; i < NSLOT; i++) if (c_ok[i]) return 1'b1;
      return 1'b0;
   endfunction

   function automatic mcrpm_pkg::rsp_type ring_predict(mcrpm_pkg::req_type q);
      logic [63:0] used, base, have, amt;
      logic [47:0] p, start, best, d;
      logic old, any;
      int c;
      c = q.client;
      amt = {17'd0, q.amount};
      case (q.action)
         mcrpm_pkg::ACT_REG_PROD: begin
            if (p_ok[c]) return mk(mcrpm_pkg::ST_ERR, '0, '0);
            p_ok[c] = 1'b1; p_com[c] = wfront; p_res[c] = wfront;
            return mk(mcrpm_pkg::ST_OK, wfront, '0);
         end
         mcrpm_pkg::ACT_REG_CONS: begin
            if (c_ok[c]) return mk(mcrpm_pkg::ST_ERR, '0, '0);
            c_ok[c] = 1'b1; c_clm[c] = rback; c_rel[c] = rback;
            return mk(mcrpm_pkg::ST_OK, rback, '0);
         end
         mcrpm_pkg::ACT_RESERVE, mcrpm_pkg::ACT_Q_WRITE, mcrpm_pkg::ACT_FIN_WRITE: begin
            if (!p_ok[c]) return mk(mcrpm_pkg::ST_ERR, '0, '0);
            if (q.action == mcrpm_pkg::ACT_FIN_WRITE) begin
               if (amt == 0) return mk(mcrpm_pkg::ST_ERR, '0, '0);
               base = {16'd0, (p_com[c] - rback) & PMASK};
               if (base > m_ring || base + amt > m_ring) return mk(mcrpm_pkg::ST_ERR, '0, '0);
               old = (p_com[c] == wfront);
               p = (p_com[c] + amt[47:0]) & PMASK;
               p_com[c] = p;
               if (old) begin
                  best = (wfront - rback) & PMASK;
                  any = 1'b0;
                  for (int i = 0; i < NSLOT; i++) if (p_ok[i]) begin
                     d = (p_com[i] - rback) & PMASK;
                     if (!any || d < best) best = d;
                     any = 1'b1;
                  end
                  wfront = (rback + best) & PMASK;
               end
               if (!any_cons()) rback = wfront;
               return mk(mcrpm_pkg::ST_OK, p, '0);
            end
            if (q.action == mcrpm_pkg::ACT_RESERVE && amt == 0)
               return mk(mcrpm_pkg::ST_ERR, '0, '0);
            used = {16'd0, (p_res[c] - rback) & PMASK};
            if (used > m_ring) return mk(mcrpm_pkg::ST_ERR, '0, '0);
            if (m_down) return mk(mcrpm_pkg::ST_DOWN, '0, '0);
            if (q.action == mcrpm_pkg::ACT_Q_WRITE)
               return mk(mcrpm_pkg::ST_OK, p_res[c], m_ring - used[46:0]);
            if (used + amt > m_ring) return mk(mcrpm_pkg::ST_WAIT, '0, '0);
            start = p_res[c];
            p_res[c] = (start + amt[47:0]) & PMASK;
            return mk(mcrpm_pkg::ST_OK, start, amt[46:0]);
         end
         mcrpm_pkg::ACT_CLAIM, mcrpm_pkg::ACT_CLAIM_ALL, mcrpm_pkg::ACT_Q_READ,
         mcrpm_pkg::ACT_FIN_READ: begin
            if (!c_ok[c]) return mk(mcrpm_pkg::ST_ERR, '0, '0);
            if (q.action == mcrpm_pkg::ACT_FIN_READ) begin
               if (amt == 0 || {16'd0, (c_clm[c] - c_rel[c]) & PMASK} < amt)
                  return mk(mcrpm_pkg::ST_ERR, '0, '0);
               old = (c_rel[c] == rback);
               p = (c_rel[c] + amt[47:0]) & PMASK;
               c_rel[c] = p;
               if (old) begin
                  best = '0; any = 1'b0;
                  for (int i = 0; i < NSLOT; i++) if (c_ok[i]) begin
                     d = (c_rel[i] - rback) & PMASK;
                     if (!any || d < best) best = d;
                     any = 1'b1;
                  end
                  rback = (rback + best) & PMASK;
               end
               return mk(mcrpm_pkg::ST_OK, p, '0);
            end
            if (q.action == mcrpm_pkg::ACT_CLAIM && amt == 0)
               return mk(mcrpm_pkg::ST_ERR, '0, '0);
            if (m_down) return mk(mcrpm_pkg::ST_DOWN, '0, '0);
            have = {16'd0, (wfront - c_clm[c]) & PMASK};
            if (have > AMAX) have = {17'd0, AMAX};
            if (q.action == mcrpm_pkg::ACT_Q_READ) begin
               if (have < amt) return mk(mcrpm_pkg::ST_WAIT, '0, '0);
               return mk(mcrpm_pkg::ST_OK, c_clm[c], have[46:0]);
            end
            if (q.action == mcrpm_pkg::ACT_CLAIM_ALL) amt = have;
            if (amt == 0 || have < amt) return mk(mcrpm_pkg::ST_WAIT, '0, '0);
            start = c_clm[c];
            c_clm[c] = (start + amt[47:0]) & PMASK;
            return mk(mcrpm_pkg::ST_OK, start, amt[46:0]);
         end
         default: return mk(mcrpm_pkg::ST_ERR, '0, '0);
      endcase
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
   endtask

   // response checker
   always @(posedge clock) begin
      mcrpm_pkg::rsp_type w;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               report_mismatch("unexpected response", 64'(rsp_data.position), 64'd0);
            end else begin
               w = pending_rsp.pop_front();
               if (rsp_data.status !== w.status)
                  report_mismatch("status", 64'(rsp_data.status), 64'(w.status));
               if (rsp_data.position !== w.position)
                  report_mismatch("position", 64'(rsp_data.position), 64'(w.position));
               if (rsp_data.avail !== w.avail)
                  report_mismatch("avail", 64'(rsp_data.avail), 64'(w.avail));
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   task automatic csr_put(logic [mcrpm_pkg::CSR_IDX_W-1:0] idx, logic [46:0] v);
      @(posedge clock);
      csr_write <= 1'b1; csr_index <= idx; csr_data <= v;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == mcrpm_pkg::CSR_RING_SIZE) m_ring = v; else m_down = v[0];
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // one request; expected result typed in when chk is set
   task automatic send_req(mcrpm_pkg::req_type q, logic chk = 1'b0,
                           mcrpm_pkg::rsp_type want = '0);
      mcrpm_pkg::rsp_type p;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= q;
      p = ring_predict(q);
      if (chk && p !== want) report_mismatch("table row", 64'(p.status), 64'(want.status));
      pending_rsp.push_back(chk ? want : p);
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic mcrpm_pkg::req_type rq(logic [3:0] a, logic [2:0] c, logic [46:0] n);
      mcrpm_pkg::req_type q;
      q.action = a; q.client = c; q.amount = n;
      return q;
   endfunction

   typedef struct {
      mcrpm_pkg::req_type q;
      logic chk;
      mcrpm_pkg::rsp_type want;
   } row_type;

   row_type dir_rows [$];

   task automatic add_row(mcrpm_pkg::req_type q, logic chk = 1'b0,
                          mcrpm_pkg::rsp_type w = '0);
      row_type r;
      r.q = q; r.chk = chk; r.want = w;
      dir_rows.push_back(r);
   endtask

   function automatic mcrpm_pkg::req_type rand_req();
      mcrpm_pkg::req_type q;
      int k;
      logic [3:0] acts [6] = '{mcrpm_pkg::ACT_RESERVE, mcrpm_pkg::ACT_FIN_WRITE,
                               mcrpm_pkg::ACT_CLAIM, mcrpm_pkg::ACT_CLAIM_ALL,
                               mcrpm_pkg::ACT_FIN_READ, mcrpm_pkg::ACT_Q_READ};
      k = $urandom_range(99);
      q.client = 3'($urandom_range(3));
      if (k < 80) q.action = acts[$urandom_range(5)];
      else if (k < 88) q.action = 4'($urandom_range(8));
      else if (k < 92) q.action = 4'($urandom_range(15));
      else q.action = mcrpm_pkg::ACT_Q_WRITE;
      if ($urandom_range(9) == 0) q.client = 3'($urandom_range(7));
      k = $urandom_range(19);
      if (k == 0) q.amount = 47'({$urandom, $urandom} & {17'd0, AMAX});
      else if (k == 1) q.amount = '0;
      else q.amount = 47'($urandom_range(1, 4000));
      if (q.action == mcrpm_pkg::ACT_Q_READ && $urandom_range(1)) q.amount = '0;
      return q;
   endfunction

   initial begin
      model_reset();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      add_row(rq(mcrpm_pkg::ACT_RESERVE, 3'd0, 47'd5), 1'b1, mk(mcrpm_pkg::ST_ERR, '0, '0));
      add_row(rq(4'd9, 3'd0, 47'd1), 1'b1, mk(mcrpm_pkg::ST_ERR, '0, '0));
      add_row(rq(4'd15, 3'd7, AMAX), 1'b1, mk(mcrpm_pkg::ST_ERR, '0, '0));
      add_row(rq(mcrpm_pkg::ACT_REG_PROD, 3'd0, '0), 1'b1, mk(mcrpm_pkg::ST_OK, '0, '0));
      add_row(rq(mcrpm_pkg::ACT_REG_PROD, 3'd0, '0), 1'b1, mk(mcrpm_pkg::ST_ERR, '0, '0));
      add_row(rq(mcrpm_pkg::ACT_REG_CONS, 3'd7, '0), 1'b1, mk(mcrpm_pkg::ST_OK, '0, '0));
      add_row(rq(mcrpm_pkg::ACT_Q_WRITE, 3'd0, '0), 1'b1,
              mk(mcrpm_pkg::ST_OK, '0, 47'd65536));
      add_row(rq(mcrpm_pkg::ACT_RESERVE, 3'd0, '0), 1'b1, mk(mcrpm_pkg::ST_ERR, '0, '0));
      add_row(rq(mcrpm_pkg::ACT_RESERVE, 3'd0, AMAX), 1'b1, mk(mcrpm_pkg::ST_WAIT, '0, '0));
      add_row(rq(mcrpm_pkg::ACT_RESERVE, 3'd0, 47'd100), 1'b1,
              mk(mcrpm_pkg::ST_OK, '0, 47'd100));
      add_row(rq(mcrpm_pkg::ACT_FIN_WRITE, 3'd0, '0), 1'b1, mk(mcrpm_pkg::ST_ERR, '0, '0));
      add_row(rq(mcrpm_pkg::ACT_FIN_WRITE, 3'd0, 47'd100));
      add_row(rq(mcrpm_pkg::ACT_Q_READ, 3'd7, 47'd200), 1'b1,
              mk(mcrpm_pkg::ST_WAIT, '0, '0));
      add_row(rq(mcrpm_pkg::ACT_Q_READ, 3'd7, '0));
      add_row(rq(mcrpm_pkg::ACT_CLAIM, 3'd7, '0), 1'b1, mk(mcrpm_pkg::ST_ERR, '0, '0));
      add_row(rq(mcrpm_pkg::ACT_CLAIM, 3'd7, 47'd40));
      add_row(rq(mcrpm_pkg::ACT_CLAIM_ALL, 3'd7, '0));
      add_row(rq(mcrpm_pkg::ACT_CLAIM_ALL, 3'd7, '0), 1'b1, mk(mcrpm_pkg::ST_WAIT, '0, '0));
      add_row(rq(mcrpm_pkg::ACT_FIN_READ, 3'd7, 47'd101), 1'b1,
              mk(mcrpm_pkg::ST_ERR, '0, '0));
      add_row(rq(mcrpm_pkg::ACT_FIN_READ, 3'd7, 47'd100));
      add_row(rq(mcrpm_pkg::ACT_REG_PROD, 3'd3, '0));
      add_row(rq(mcrpm_pkg::ACT_REG_CONS, 3'd2, '0));
      add_row(rq(mcrpm_pkg::ACT_FIN_WRITE, 3'd3, AMAX), 1'b1, mk(mcrpm_pkg::ST_ERR, '0, '0));
      foreach (dir_rows[i]) send_req(dir_rows[i].q, dir_rows[i].chk, dir_rows[i].want);
      drain();

      csr_put(mcrpm_pkg::CSR_SHUT_DOWN, 47'd1);
      send_req(rq(mcrpm_pkg::ACT_Q_WRITE, 3'd0, '0), 1'b1, mk(mcrpm_pkg::ST_DOWN, '0, '0));
      send_req(rq(mcrpm_pkg::ACT_CLAIM_ALL, 3'd7, '0), 1'b1, mk(mcrpm_pkg::ST_DOWN, '0, '0));
      send_req(rq(mcrpm_pkg::ACT_FIN_WRITE, 3'd0, 47'd1));
      drain();
      csr_put(mcrpm_pkg::CSR_SHUT_DOWN, 47'd0);
      csr_put(mcrpm_pkg::CSR_RING_SIZE, 47'd1);
      send_req(rq(mcrpm_pkg::ACT_RESERVE, 3'd3, 47'd2), 1'b1, mk(mcrpm_pkg::ST_WAIT, '0, '0));
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: csr_put(mcrpm_pkg::CSR_RING_SIZE, AMAX);
            1: csr_put(mcrpm_pkg::CSR_RING_SIZE, 47'd5000);
            2: csr_put(mcrpm_pkg::CSR_RING_SIZE, 47'd300);
            3: csr_put(mcrpm_pkg::CSR_RING_SIZE, 47'd65536);
            4: csr_put(mcrpm_pkg::CSR_SHUT_DOWN, 47'd1);
            default: begin
               csr_put(mcrpm_pkg::CSR_SHUT_DOWN, 47'd0);
               csr_put(mcrpm_pkg::CSR_RING_SIZE, 47'd20000);
            end
         endcase
         send_idle = (ph < 2) ? 22 : (ph < 4) ? 59 : 0;
         recv_idle = (ph < 2) ? 59 : (ph < 4) ? 22 : 0;
         for (int n = 0; n < 320; n++) begin
            if (n == 150) drain();
            send_req(rand_req());
         end
         drain();
      end

      recv_idle = 0;
      drain();
      if (errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

   initial begin
      #4000000;
      $display("FAIL");
      $finish;
   end

endmodule
